// File: src/dmx_channel_change_encoder_macros.svh
// assertion macros of the port checker file
`ifndef DMX_CHANNEL_CHANGE_ENCODER_MACROS_SVH
`define DMX_CHANNEL_CHANGE_ENCODER_MACROS_SVH

// same-cycle implication, checked on clk_i outside reset
`define DMXCCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i outside reset
`define DMXCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dmxcce_pkg.sv
// types and constants of the channel change encoder
package dmxcce_pkg;

  // default number of lighting channels
  localparam int unsigned CHANNELS = 512;

  localparam int unsigned CHAN_W  = 9;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned BYTE_W  = 8;

  // command bytes of the adapter stream
  localparam logic [BYTE_W-1:0] CMD_NOOP     = 8'h26;
  localparam logic [BYTE_W-1:0] CMD_TX_ON    = 8'h44;
  localparam logic [BYTE_W-1:0] CMD_SET_LOW  = 8'h48;
  localparam logic [BYTE_W-1:0] CMD_SET_HIGH = 8'h49;

  // channels below this use the low range command
  localparam logic [CHAN_W-1:0] LOW_RANGE_LIMIT = 9'd256;

  // position of a byte within the run of one item
  localparam int unsigned BYTE_IDX_W = 3;
  localparam logic [BYTE_IDX_W-1:0] BYTE_FIRST = 3'd0;
  localparam logic [BYTE_IDX_W-1:0] BYTE_TX_ON = 3'd4;
  localparam logic [BYTE_IDX_W-1:0] BYTE_RANGE = 3'd5;
  localparam logic [BYTE_IDX_W-1:0] BYTE_CHAN  = 3'd6;
  localparam logic [BYTE_IDX_W-1:0] BYTE_LEVEL = 3'd7;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
  } out_t;

endpackage

// File: src/dmxcce_ram.sv
// generic single write port ram with registered read
module dmxcce_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: src/dmx_channel_change_encoder.sv
// top level of the lighting channel change encoder
//
// Input channel: one beat carries a channel number and its new level. Output
// channel: one beat carries one command byte and a flag on the last byte of
// the run caused by one input beat. Both channels use valid/ready.
// The last level sent per channel sits in a ram of Channels entries. An input
// beat reads its entry at acceptance, the next cycle compares, a changed level is
// written back as it leaves the compare stage (a register of the last write forwards
// to a read of the same entry), and a changed level or the start-up preamble loads
// the byte emitter. An input beat is registered in the compare stage, then in the
// emitter, which drives the output. Throughput: the emitter sends one byte per cycle
// while out_ready_i is high; a changed level sends three bytes, the first item five
// or eight, and an unchanged level none. Reset: a clearing pass zeros the ram, one
// entry per cycle, through all Channels entries; in_ready_o stays low until it ends.
// The preamble (four no-op bytes and a transmit-on byte) precedes the bytes of the
// first item after reset. A stalled receiver holds the emitter; items with nothing
// to send still pass the compare stage one per cycle, and the first item with bytes
// waits there with in_ready_o low until the emitter frees up.
module dmx_channel_change_encoder #(
  parameter int unsigned Channels = dmxcce_pkg::CHANNELS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dmxcce_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dmxcce_pkg::out_t  out_data_o
);

  localparam int unsigned AddrW = $clog2(Channels);
  localparam int unsigned LvW   = dmxcce_pkg::LEVEL_W;
  localparam int unsigned ChW   = dmxcce_pkg::CHAN_W;
  localparam int unsigned IdxW  = dmxcce_pkg::BYTE_IDX_W;

  // clearing pass state
  logic             clr_active_q, clr_active_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;

  logic tx_started_q, tx_started_d;

  // compare stage
  logic             s1_valid_q, s1_valid_d;
  logic             s1_pre_q;
  logic             s1_rd_q;
  logic [ChW-1:0]   s1_ch_q;
  logic [LvW-1:0]   s1_lv_q;

  // last write, forwarded to the compare stage
  logic             wr_valid_q, wr_valid_d;
  logic [AddrW-1:0] wr_addr_q;
  logic [LvW-1:0]   wr_lv_q;

  // byte emitter
  logic             em_valid_q, em_valid_d;
  logic [IdxW-1:0]  em_idx_q, em_idx_d;
  logic [IdxW-1:0]  em_end_q;
  logic [ChW-1:0]   em_ch_q;
  logic [LvW-1:0]   em_lv_q;

  logic             in_accept;
  logic             in_range;
  logic             rd_en;
  logic [LvW-1:0]   rd_data;
  logic [LvW-1:0]   old_lv;
  logic             s1_chg;
  logic             s1_emits;
  logic             s1_go;
  logic             em_last;
  logic             em_free;
  logic             em_load;
  logic             out_take;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [LvW-1:0]   mem_wdata;

  // input handshake and ram read
  assign in_range   = 32'(in_data_i.channel) < Channels;
  assign in_ready_o = !clr_active_q && (!s1_valid_q || s1_go);
  assign in_accept  = in_valid_i && in_ready_o;
  assign rd_en      = in_accept && in_range;

  // compare against the stored level, forwarding the last write
  assign old_lv   = (wr_valid_q && (wr_addr_q == s1_ch_q[AddrW-1:0])) ? wr_lv_q : rd_data;
  assign s1_chg   = s1_rd_q && (old_lv != s1_lv_q);
  assign s1_emits = s1_pre_q || s1_chg;

  // emitter flow control
  assign out_take = em_valid_q && out_ready_i;
  assign em_last  = (em_idx_q == em_end_q);
  assign em_free  = !em_valid_q || (out_take && em_last);
  assign s1_go    = s1_valid_q && (!s1_emits || em_free);
  assign em_load  = s1_go && s1_emits;

  // ram write: clearing pass or level update
  assign mem_we    = clr_active_q || (s1_go && s1_chg);
  assign mem_waddr = clr_active_q ? clr_addr_q : s1_ch_q[AddrW-1:0];
  assign mem_wdata = clr_active_q ? '0 : s1_lv_q;

  dmxcce_ram #(
    .Width (LvW),
    .Depth (Channels)
  ) u_levels (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (in_data_i.channel[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  // next control state
  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      if (clr_addr_q == AddrW'(Channels - 1)) begin
        clr_active_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end

    tx_started_d = tx_started_q || in_accept;

    s1_valid_d = in_accept || (s1_valid_q && !s1_go);

    wr_valid_d = clr_active_q ? 1'b0 : (wr_valid_q || (s1_go && s1_chg));

    em_valid_d = em_valid_q;
    em_idx_d   = em_idx_q;
    if (em_load) begin
      em_valid_d = 1'b1;
      em_idx_d   = s1_pre_q ? dmxcce_pkg::BYTE_FIRST : dmxcce_pkg::BYTE_RANGE;
    end else if (out_take) begin
      if (em_last) begin
        em_valid_d = 1'b0;
      end else begin
        em_idx_d = em_idx_q + 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      tx_started_q <= 1'b0;
      s1_valid_q   <= 1'b0;
      wr_valid_q   <= 1'b0;
      em_valid_q   <= 1'b0;
      em_idx_q     <= dmxcce_pkg::BYTE_FIRST;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      tx_started_q <= tx_started_d;
      s1_valid_q   <= s1_valid_d;
      wr_valid_q   <= wr_valid_d;
      em_valid_q   <= em_valid_d;
      em_idx_q     <= em_idx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pre_q <= !tx_started_q;
      s1_rd_q  <= in_range;
      s1_ch_q  <= in_data_i.channel;
      s1_lv_q  <= in_data_i.level;
    end
    if (s1_go && s1_chg) begin
      wr_addr_q <= s1_ch_q[AddrW-1:0];
      wr_lv_q   <= s1_lv_q;
    end
    if (em_load) begin
      em_end_q <= s1_chg ? dmxcce_pkg::BYTE_LEVEL : dmxcce_pkg::BYTE_TX_ON;
      em_ch_q  <= s1_ch_q;
      em_lv_q  <= s1_lv_q;
    end
  end

  // output byte select
  always_comb begin
    unique case (em_idx_q)
      dmxcce_pkg::BYTE_TX_ON: out_data_o.out_byte = dmxcce_pkg::CMD_TX_ON;
      dmxcce_pkg::BYTE_RANGE: begin
        out_data_o.out_byte = (em_ch_q < dmxcce_pkg::LOW_RANGE_LIMIT) ?
                              dmxcce_pkg::CMD_SET_LOW : dmxcce_pkg::CMD_SET_HIGH;
      end
      dmxcce_pkg::BYTE_CHAN:  out_data_o.out_byte = em_ch_q[7:0];
      dmxcce_pkg::BYTE_LEVEL: out_data_o.out_byte = em_lv_q;
      default:                out_data_o.out_byte = dmxcce_pkg::CMD_NOOP;
    endcase
    out_data_o.run_last = em_last;
  end

  assign out_valid_o = em_valid_q;

endmodule

// File: src/dmxcce_checker.sv
// port checker of the channel change encoder and its bind
`include "dmx_channel_change_encoder_macros.svh"

module dmxcce_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input dmxcce_pkg::in_t  in_data_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input dmxcce_pkg::out_t out_data_o
);

  // a stalled input beat holds
  `DMXCCE_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o,
    in_valid_i && $stable(in_data_i), "input beat dropped or changed while stalled")

  // a stalled output beat holds
  `DMXCCE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o), "output beat dropped or changed while stalled")

  // bytes of one run follow without a gap
  `DMXCCE_ASSERT_NEXT(a_run_cont, out_valid_o && out_ready_i && !out_data_o.run_last,
    out_valid_o, "gap inside a run of output bytes")

  // clearing pass keeps the input closed right after reset
  `DMXCCE_ASSERT_NOW(a_clear_after_reset, !$past(rst_ni),
    !in_ready_o && !out_valid_o, "block open before the clearing pass")

endmodule

bind dmx_channel_change_encoder dmxcce_checker u_checker (.*);

// File: dv/dmx_channel_change_encoder_checker.sv
`timescale 1ns / 1ps
// checker of the channel change encoder: predicts the command bytes and compares them
module dmx_channel_change_encoder_checker #(
  parameter int unsigned Channels = dmxcce_pkg::CHANNELS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  dmxcce_pkg::in_t   in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  dmxcce_pkg::out_t  out_data_i,
  output int                errors_o,
  output int                pending_o
);
  import dmxcce_pkg::*;

  // last level sent per channel, as the adapter should have seen it
  bit [LEVEL_W-1:0] level_mirror [Channels];
  bit               preamble_sent;
  out_t             expected_bytes [$];
  int               error_cnt;

  // bytes that one accepted input beat should cause, in order
  task automatic queue_command_run(in_t item);
    logic [BYTE_W-1:0] run_bytes [8];
    int                n;
    out_t              beat;
    n = 0;
    // start-up preamble ahead of the first item
    if (!preamble_sent) begin
      preamble_sent = 1'b1;
      for (int k = 0; k < 4; k++) begin
        run_bytes[n] = CMD_NOOP;
        n++;
      end
      run_bytes[n] = CMD_TX_ON;
      n++;
      foreach (level_mirror[c]) level_mirror[c] = '0;
    end
    // changed level on a channel in range
    if (item.channel < Channels && level_mirror[item.channel] != item.level) begin
      level_mirror[item.channel] = item.level;
      run_bytes[n] = (item.channel < LOW_RANGE_LIMIT) ? CMD_SET_LOW : CMD_SET_HIGH;
      run_bytes[n+1] = item.channel[BYTE_W-1:0];
      run_bytes[n+2] = item.level;
      n += 3;
    end
    for (int k = 0; k < n; k++) begin
      beat.out_byte = run_bytes[k];
      beat.run_last = (k == n - 1);
      expected_bytes.push_back(beat);
    end
  endtask

  // compare one output beat with the oldest expected byte
  task automatic check_command_byte(out_t got);
    out_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected output beat: out_byte %02h run_last %0b", got.out_byte, got.run_last);
      error_cnt++;
      return;
    end
    want = expected_bytes.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte mismatch: expected %02h, actual %02h", want.out_byte, got.out_byte);
      error_cnt++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last mismatch: expected %0b, actual %0b", want.run_last, got.run_last);
      error_cnt++;
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (level_mirror[c]) level_mirror[c] = '0;
      preamble_sent = 1'b0;
      expected_bytes.delete();
      error_cnt = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) queue_command_run(in_data_i);
      if (out_valid_i && out_ready_i) check_command_byte(out_data_i);
      errors_o  <= error_cnt;
      pending_o <= expected_bytes.size();
    end
  end

endmodule

// File: dv/dmx_channel_change_encoder_tb.sv
`timescale 1ns / 1ps
// testbench top of the channel change encoder: stimulus, idling and verdict
module dmx_channel_change_encoder_tb;
  import dmxcce_pkg::*;

  localparam int unsigned PhaseItems = 98;
  localparam int unsigned NumPhases  = 4;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned NumDirected = 18;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  int          mismatches;
  int          bytes_pending;
  int unsigned cycle_cnt = 0;
  bit          sender_gaps_en   = 1'b0;
  bit          receiver_gaps_en = 1'b0;
  int unsigned receiver_hold    = 0;

  // edges of the ranges, preamble on an unchanged first level, repeats on one channel
  int unsigned directed_chan [NumDirected] = '{
    0, 0, 255, 256, 511, 511, 511, 1, 1, 1, 1, 257, 170, 341, 256, 0, 0, 2
  };
  int unsigned directed_level [NumDirected] = '{
    0, 255, 1, 128, 255, 255, 0, 1, 1, 2, 1, 170, 85, 85, 128, 0, 0, 255
  };

  dmx_channel_change_encoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  dmx_channel_change_encoder_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .errors_o    (mismatches),
    .pending_o   (bytes_pending)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // channels cluster on a few hot spots so levels repeat and change often
  function automatic in_t pick_item();
    in_t         item;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35)      item.channel = CHAN_W'($urandom_range(0, 3));
    else if (roll < 50) item.channel = CHAN_W'($urandom_range(254, 257));
    else if (roll < 60) item.channel = CHAN_W'($urandom_range(508, 511));
    else                item.channel = CHAN_W'($urandom_range(0, 511));
    roll = $urandom_range(0, 99);
    if (roll < 45)      item.level = LEVEL_W'($urandom_range(0, 2));
    else if (roll < 55) item.level = 8'hff;
    else                item.level = LEVEL_W'($urandom_range(0, 255));
    return item;
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    if (receiver_gaps_en && receiver_hold == 0 && $urandom_range(0, 3) == 0)
      receiver_hold = pick_gap();
    if (receiver_hold > 0) begin
      out_ready_i <= 1'b0;
      receiver_hold--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // present one beat after an optional gap and hold it until accepted
  task automatic send_beat(in_t item);
    int unsigned gap;
    gap = sender_gaps_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // sender holds off until every expected byte has come out
  task automatic wait_all_bytes();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (bytes_pending != 0);
  endtask

  initial begin
    in_t item;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items, no idling
    for (int i = 0; i < NumDirected; i++) begin
      item.channel = CHAN_W'(directed_chan[i]);
      item.level   = LEVEL_W'(directed_level[i]);
      send_beat(item);
    end
    wait_all_bytes();

    // random phases: both sides idle, none, sender only, receiver only
    for (int p = 0; p < NumPhases; p++) begin
      sender_gaps_en   = (p == 0) || (p == 2);
      receiver_gaps_en = (p == 0) || (p == 3);
      for (int i = 0; i < PhaseItems; i++) send_beat(pick_item());
      wait_all_bytes();
    end

    // let any late or stray beat show up
    repeat (20) @(posedge clk_i);
    if (bytes_pending != 0)
      $error("%0d expected output beats never arrived", bytes_pending);
    if (mismatches == 0 && bytes_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/dmxcce_pkg.sv
src/dmxcce_ram.sv
src/dmx_channel_change_encoder.sv
src/dmxcce_checker.sv
dv/dmx_channel_change_encoder_checker.sv
dv/dmx_channel_change_encoder_tb.sv
